// File: src/assert_macros.svh
// assertion macros shared by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define ASSERT_SAME(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// next-cycle implication, disabled while reset is high
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// File: src/ppmm_pkg.sv
// shared types and constants of the per-pixel min/max midpoint unit
package ppmm_pkg;

   localparam int PIXEL_W            = 8;
   localparam int FRAME_PIXELS_W     = 17;
   localparam int INDEX_W            = 16;
   localparam int MAX_PIXELS_DEFAULT = 65536;
   localparam int FRAME_PIXELS_RESET = 65536;

   typedef logic [PIXEL_W-1:0] pixel_type;
   typedef logic [INDEX_W-1:0] index_type;

   // one entry of the running store
   typedef struct packed {
      pixel_type hi;
      pixel_type lo;
   } minmax_type;

endpackage

// File: src/ppmm_ram.sv
// generic single-write, single-read ram with registered read data
module ppmm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 65536
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port, holds its data while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

// File: src/per_pixel_min_max_midpoint_unit.sv
// top level of the per-pixel min/max midpoint unit
// Pixels of a frame sequence stream in raster order, one beat per clock when
// the result side keeps up. Each beat reads its raster entry of the min/max
// ram in the cycle it is accepted, then folds the pixel in and writes the
// entry back from stage one; a pixel of the first frame loads the entry from
// its own value. On last-frame beats the truncated mean (max + min) / 2 is
// loaded from stage one into the output register, tagged with the raster
// index, and the final pixel of the frame is marked. Back-to-back beats on the
// same entry (a one-pixel frame) are forwarded around the ram. The ram's single
// read and single write port set the rate at one pixel per cycle; req_stall
// rises only while a finished result waits on rsp_stall and the next
// last-frame beat has nowhere to go. Writing frame_pixels returns the raster
// position to zero; 0 or a value above MAX_PIXELS means MAX_PIXELS. The ram has
// no reset and no clearing pass: the first frame must be sent before others.
module per_pixel_min_max_midpoint_unit
   import ppmm_pkg::*;
#(
   parameter int MAX_PIXELS = MAX_PIXELS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   // configuration
   input  logic                      csr_wr_en,
   input  logic [FRAME_PIXELS_W-1:0] csr_wr_data,
   // pixel beats
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [PIXEL_W-1:0]        req_pixel,
   input  logic                      req_first_frame,
   input  logic                      req_last_frame,
   // midpoint beats
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [PIXEL_W-1:0]        rsp_midpoint,
   output logic [INDEX_W-1:0]        rsp_pixel_index,
   output logic                      rsp_last_pixel
);

   localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
   localparam int CW = (AW + 1 > FRAME_PIXELS_W) ? AW + 1 : FRAME_PIXELS_W;
   localparam logic [AW-1:0] LAST_IDX_MAX   = AW'(MAX_PIXELS - 1);
   localparam logic [AW-1:0] LAST_IDX_RESET = (FRAME_PIXELS_RESET > MAX_PIXELS) ?
                                              AW'(MAX_PIXELS - 1) :
                                              AW'(FRAME_PIXELS_RESET - 1);

   // control registers
   logic [AW-1:0] last_idx_ff, last_idx_in;
   logic [AW-1:0] position_ff, position_in;
   logic          s1_valid_ff, s1_valid_in;
   logic          out_valid_ff, out_valid_in;

   // payload registers
   pixel_type     s1_pixel_ff;
   logic          s1_first_ff;
   logic          s1_last_ff;
   logic [AW-1:0] s1_idx_ff;
   logic          s1_eof_ff;
   logic          s1_fwd_ff;
   minmax_type    s1_fwd_data_ff;
   pixel_type     out_mid_ff;
   index_type     out_idx_ff;
   logic          out_last_ff;

   logic          req_accept;
   logic          out_free;
   logic          s1_done;
   logic          at_eof;
   logic          oversize;
   minmax_type    rd_data;
   minmax_type    stored;
   minmax_type    folded;
   logic [PIXEL_W:0] sum;

   // handshake
   assign req_accept = req_valid & ~req_stall;
   assign out_free   = ~out_valid_ff | ~rsp_stall;
   assign s1_done    = s1_valid_ff & (~s1_last_ff | out_free);
   assign req_stall  = s1_valid_ff & ~s1_done;

   // frame size decode on register write
   assign oversize = (csr_wr_data == '0) || (CW'(csr_wr_data) > CW'(MAX_PIXELS));
   assign last_idx_in = oversize ? LAST_IDX_MAX : AW'(csr_wr_data - 1'b1);

   // raster position
   assign at_eof = (position_ff == last_idx_ff);
   always_comb begin
      position_in = position_ff;
      if (csr_wr_en) begin
         position_in = '0;
      end else if (req_accept) begin
         position_in = at_eof ? '0 : position_ff + AW'(1);
      end
   end

   // min/max store
   ppmm_ram #(
      .WIDTH ($bits(minmax_type)),
      .DEPTH (MAX_PIXELS)
   ) u_store (
      .clock   (clock),
      .wr_en   (s1_done),
      .wr_addr (s1_idx_ff),
      .wr_data (folded),
      .rd_en   (req_accept),
      .rd_addr (position_ff),
      .rd_data (rd_data)
   );

   // fold the pixel into its entry, with forwarding from the previous write
   assign stored = s1_fwd_ff ? s1_fwd_data_ff : rd_data;
   always_comb begin
      folded = stored;
      if (s1_first_ff) begin
         folded.lo = s1_pixel_ff;
         folded.hi = s1_pixel_ff;
      end else begin
         if (s1_pixel_ff < stored.lo) begin
            folded.lo = s1_pixel_ff;
         end
         if (s1_pixel_ff > stored.hi) begin
            folded.hi = s1_pixel_ff;
         end
      end
   end
   assign sum = {1'b0, folded.hi} + {1'b0, folded.lo};

   assign s1_valid_in  = req_accept | (s1_valid_ff & ~s1_done);
   always_comb begin
      out_valid_in = out_valid_ff;
      if (s1_done & s1_last_ff) begin
         out_valid_in = 1'b1;
      end else if (~rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         last_idx_ff  <= LAST_IDX_RESET;
         position_ff  <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            last_idx_ff <= last_idx_in;
         end
         position_ff  <= position_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // stage one payload
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_pixel_ff    <= req_pixel;
         s1_first_ff    <= req_first_frame;
         s1_last_ff     <= req_last_frame;
         s1_idx_ff      <= position_ff;
         s1_eof_ff      <= at_eof;
         s1_fwd_ff      <= s1_done & (s1_idx_ff == position_ff);
         s1_fwd_data_ff <= folded;
      end
   end

   // output register payload
   always_ff @(posedge clock) begin
      if (s1_done & s1_last_ff) begin
         out_mid_ff  <= PIXEL_W'(sum >> 1);
         out_idx_ff  <= INDEX_W'(s1_idx_ff);
         out_last_ff <= s1_eof_ff;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_midpoint    = out_mid_ff;
   assign rsp_pixel_index = out_idx_ff;
   assign rsp_last_pixel  = out_last_ff;

endmodule

// File: src/ppmm_checker.sv
// port-level checks of the per-pixel min/max midpoint unit, bound to the top
`include "assert_macros.svh"

module ppmm_checker
   import ppmm_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_stall,
   input logic                      req_last_frame,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input logic [PIXEL_W-1:0]        rsp_midpoint,
   input logic [INDEX_W-1:0]        rsp_pixel_index,
   input logic                      rsp_last_pixel
);

   logic                       rsp_blocked;
   logic                       last_take;
   logic [PIXEL_W+INDEX_W:0]   rsp_payload;

   assign rsp_blocked = rsp_valid && rsp_stall;
   assign last_take   = req_valid && !req_stall && req_last_frame;
   assign rsp_payload = {rsp_midpoint, rsp_pixel_index, rsp_last_pixel};

   // a stalled result beat stays valid
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_blocked, rsp_valid)

   // a stalled result beat keeps its payload
   `ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_blocked, $stable(rsp_payload))

   // input stalls only behind a blocked result
   `ASSERT_SAME(a_stall_cause, clock, reset, req_stall, rsp_blocked)

   // a fresh result traces back to an accepted last-frame beat
   `ASSERT_SAME(a_rsp_origin, clock, reset, $rose(rsp_valid) && $past(!reset, 2), $past(last_take, 2))

endmodule

bind per_pixel_min_max_midpoint_unit ppmm_checker u_ppmm_checker (.*);
